// ----- hw/rtl/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// Process slot scheduler package
// Shared types, constants and command codes.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int SlotCount = 16;
    localparam int SlotBits  = $clog2(SlotCount);
    localparam int TimeBits  = 32;
    localparam int PrioBits  = 5;
    localparam int QuantBits = 5;
    localparam int CntBits   = $clog2(SlotCount + 1);

    localparam logic signed [PrioBits-1:0] PRIO_TOP    = -5'sd10;
    localparam logic signed [PrioBits-1:0] PRIO_BOTTOM = 5'sd10;

    typedef enum logic [1:0] {
        CMD_CREATE   = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_SLEEP    = 2'd2,
        CMD_SCHEDULE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_RR  = 2'd0,
        MODE_ML  = 2'd1,
        MODE_MLF = 2'd2,
        MODE_RSV = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DEAD  = 2'd0,
        ST_RUN   = 2'd1,
        ST_SLEEP = 2'd2,
        ST_FREE3 = 2'd3
    } status_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // capture the input transaction
        logic wake;   // wake all expired sleepers
        logic start;  // reset scan registers
        logic step;   // examine one slot
        logic apply;  // commit the command
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic     is_scan;
        logic     scan_last;
    } dp_stat_t;

endpackage

// ----- hw/rtl/process_slot_scheduler.sv -----
// ----------------------------------------------------------------------------
// Process slot scheduler
// Slot table with create, delete, sleep and schedule commands.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         command, target, priority, sleep and current time, slot
// m_axis    out        result slot, ok, quantum
// cfg       in         sched_mode
//
// Each transaction runs accept, wake, start, scan, commit and result; schedule
// scans 15 slots, create scans from slot 0 until it finds the first free slot,
// and delete and sleep skip the scan. Reset is synchronous and active low and
// marks all slots dead.
// A result waits in the output register while the next command is accepted;
// the next result stalls until that register is drained.
module process_slot_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], target_slot[5:2], new_prio[11:6], sleep_seconds[43:12],
    // now_seconds[75:44], current_slot[79:76]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_slot[3:0], ok[4], result_quantum[9:5]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    logic [1:0]        mode_reg;
    pss_pkg::dp_cmd_t  cmd;
    pss_pkg::dp_stat_t stat;
    logic              res_load;
    logic [3:0]        rs;
    logic              rok;
    logic [4:0]        rq;
    logic [9:0]        out_reg;

    // The mode changes only while no command is in flight.
    assign cfg_ready = s_tready && !m_tvalid;
    always_ff @(posedge aclk) begin
        if (!aresetn) mode_reg <= pss_pkg::MODE_RR;
        else if (cfg_valid && cfg_ready) mode_reg <= cfg_data;
    end

    pss_control u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .res_load(res_load),
        .cmd(cmd), .stat(stat)
    );

    pss_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat), .mode(mode_reg),
        .in_data(s_tdata), .res_slot(rs), .res_ok(rok), .res_quantum(rq)
    );

    always_ff @(posedge aclk) begin
        if (res_load) out_reg <= {rq, rok, rs};
    end
    assign m_tdata = {6'b0, out_reg};

endmodule

// ----- hw/rtl/pss_datapath.sv -----
// ----------------------------------------------------------------------------
// Process slot scheduler datapath
// Slot table, scan pointer and the per-slot compare logic.
// ----------------------------------------------------------------------------
module pss_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pss_pkg::dp_cmd_t            cmd,
    output pss_pkg::dp_stat_t           stat,
    input  logic [1:0]                  mode,
    input  logic [79:0]                 in_data,
    output logic [pss_pkg::SlotBits-1:0]  res_slot,
    output logic                        res_ok,
    output logic [pss_pkg::QuantBits-1:0] res_quantum
);

    localparam int SB = pss_pkg::SlotBits;
    localparam int PB = pss_pkg::PrioBits;
    localparam int QB = pss_pkg::QuantBits;
    localparam int TB = pss_pkg::TimeBits;

    pss_pkg::status_t              status_reg [pss_pkg::SlotCount];
    logic signed [PB-1:0]          prio_reg   [pss_pkg::SlotCount];
    logic [TB-1:0]                 wake_reg   [pss_pkg::SlotCount];
    logic [QB-1:0]                 quant_reg  [pss_pkg::SlotCount];

    logic [1:0]           ccmd_reg;
    logic [SB-1:0]        tgt_reg;
    logic signed [5:0]    nprio_reg;
    logic [31:0]          secs_reg;
    logic [TB-1:0]        now_reg;
    logic [SB-1:0]        cur_reg;

    logic [pss_pkg::CntBits-1:0] k_reg;
    logic [SB-1:0]        best_reg;
    logic                 found_reg;
    logic [SB-1:0]        idx;
    logic                 fb;
    logic                 ml;
    logic signed [PB-1:0] cprio;
    logic signed [PB-1:0] aged;

    assign fb = (mode == pss_pkg::MODE_MLF);
    assign ml = (mode == pss_pkg::MODE_ML) || fb;

    // Create scans from slot 0; schedule scans cur+1 .. cur+N-1.
    always_comb begin
        if (ccmd_reg == pss_pkg::CMD_CREATE) begin
            idx = k_reg[SB-1:0];
        end else begin
            idx = cur_reg + k_reg[SB-1:0];
        end
    end

    assign stat.is_scan   = (ccmd_reg == pss_pkg::CMD_CREATE)
                         || (ccmd_reg == pss_pkg::CMD_SCHEDULE);
    assign stat.scan_last = (ccmd_reg == pss_pkg::CMD_CREATE)
                         ? (k_reg == pss_pkg::CntBits'(pss_pkg::SlotCount - 1)) || found_reg
                         : (k_reg == pss_pkg::CntBits'(pss_pkg::SlotCount - 1));

    always_comb begin
        if (nprio_reg > 6'sd10) begin
            cprio = pss_pkg::PRIO_BOTTOM;
        end else if (nprio_reg < -6'sd10) begin
            cprio = pss_pkg::PRIO_TOP;
        end else begin
            cprio = nprio_reg[PB-1:0];
        end
        if (prio_reg[cur_reg] < pss_pkg::PRIO_BOTTOM) begin
            aged = prio_reg[cur_reg] + PB'(1);
        end else begin
            aged = pss_pkg::PRIO_BOTTOM;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ccmd_reg  <= in_data[1:0];
            tgt_reg   <= in_data[5:2];
            nprio_reg <= in_data[11:6];
            secs_reg  <= in_data[43:12];
            now_reg   <= in_data[75:44];
            cur_reg   <= in_data[79:76];
        end
        if (cmd.start) begin
            if (ccmd_reg == pss_pkg::CMD_CREATE) begin
                k_reg <= '0;
                found_reg <= 1'b0;
                best_reg <= '0;
            end else begin
                k_reg <= pss_pkg::CntBits'(1);
                found_reg <= 1'b0;
                best_reg <= (status_reg[cur_reg] == pss_pkg::ST_RUN) ? cur_reg : '0;
            end
        end
        if (cmd.step) begin
            if (ccmd_reg == pss_pkg::CMD_CREATE) begin
                if (!found_reg) begin
                    if (status_reg[idx] != pss_pkg::ST_RUN
                        && status_reg[idx] != pss_pkg::ST_SLEEP) begin
                        found_reg <= 1'b1;
                        best_reg  <= idx;
                    end else begin
                        k_reg <= k_reg + pss_pkg::CntBits'(1);
                    end
                end
            end else begin
                if (status_reg[idx] == pss_pkg::ST_RUN) begin
                    if (ml) begin
                        if (prio_reg[idx] <= prio_reg[best_reg]) begin
                            best_reg <= idx;
                        end
                    end else if (!found_reg) begin
                        found_reg <= 1'b1;
                        best_reg  <= idx;
                    end
                end
                k_reg <= k_reg + pss_pkg::CntBits'(1);
            end
        end
    end

    // Slot table; status resets, other fields reset to zero as well.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pss_pkg::SlotCount; i++) begin
                status_reg[i] <= pss_pkg::ST_DEAD;
                prio_reg[i]   <= '0;
                wake_reg[i]   <= '0;
                quant_reg[i]  <= '0;
            end
        end else begin
            // Only a schedule command wakes expired sleepers.
            if (cmd.wake && ccmd_reg == pss_pkg::CMD_SCHEDULE) begin
                for (int i = 0; i < pss_pkg::SlotCount; i++) begin
                    if (status_reg[i] == pss_pkg::ST_SLEEP && now_reg >= wake_reg[i]) begin
                        status_reg[i] <= pss_pkg::ST_RUN;
                    end
                end
            end
            if (cmd.apply) begin
                case (ccmd_reg)
                    pss_pkg::CMD_CREATE: begin
                        if (found_reg) begin
                            status_reg[best_reg] <= pss_pkg::ST_RUN;
                            prio_reg[best_reg]   <= cprio;
                            quant_reg[best_reg]  <= '0;
                        end
                    end
                    pss_pkg::CMD_DELETE: begin
                        status_reg[tgt_reg] <= pss_pkg::ST_DEAD;
                        wake_reg[tgt_reg]   <= '0;
                        quant_reg[tgt_reg]  <= '0;
                        if (fb) prio_reg[tgt_reg] <= pss_pkg::PRIO_TOP;
                    end
                    pss_pkg::CMD_SLEEP: begin
                        status_reg[tgt_reg] <= pss_pkg::ST_SLEEP;
                        wake_reg[tgt_reg]   <= now_reg + secs_reg;
                        if (fb) prio_reg[tgt_reg] <= pss_pkg::PRIO_TOP;
                    end
                    default: begin
                        if (fb) begin
                            prio_reg[cur_reg]  <= aged;
                            quant_reg[cur_reg] <= QB'(aged + PB'(10));
                        end
                    end
                endcase
            end
        end
    end

    // The result is formed after the commit, so an aged quantum is reported.
    always_comb begin
        res_slot    = '0;
        res_ok      = 1'b1;
        res_quantum = '0;
        case (ccmd_reg)
            pss_pkg::CMD_CREATE: begin
                res_ok   = found_reg;
                res_slot = found_reg ? best_reg : '0;
            end
            pss_pkg::CMD_SCHEDULE: begin
                res_slot    = (ml || found_reg) ? best_reg
                            : ((status_reg[cur_reg] == pss_pkg::ST_RUN) ? cur_reg : '0);
                res_quantum = quant_reg[res_slot];
            end
            default: ;
        endcase
    end

endmodule

// ----- hw/rtl/pss_control.sv -----
// ----------------------------------------------------------------------------
// Process slot scheduler controller
// Sequences load, wake, scan, commit and output of one command.
// ----------------------------------------------------------------------------
module pss_control (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                res_load,
    output pss_pkg::dp_cmd_t    cmd,
    input  pss_pkg::dp_stat_t   stat
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WAKE  = 6'b000010,
        S_START = 6'b000100,
        S_SCAN  = 6'b001000,
        S_RES   = 6'b010000,
        S_APPLY = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    always_comb begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        res_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load = in_valid;
                if (in_valid) state_next = S_WAKE;
            end
            S_WAKE: begin
                cmd.wake   = 1'b1;
                state_next = S_START;
            end
            S_START: begin
                cmd.start  = 1'b1;
                state_next = stat.is_scan ? S_SCAN : S_APPLY;
            end
            S_SCAN: begin
                cmd.step = 1'b1;
                if (stat.scan_last) state_next = S_APPLY;
            end
            S_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = S_RES;
            end
            S_RES: begin
                // Wait for the output register to free up.
                if (!ov_reg || out_ready) begin
                    res_load   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule
